// ===== hdl/source_tokenizer_assert.svh =====
// Assertion macros used by the tokenizer's top-level module.
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// Same-cycle implication under clock and active-low reset.
`define STOK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under clock and active-low reset.
`define STOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/stok_pkg.sv =====
package stok_pkg;

  localparam int unsigned MaxTokenLen = 127;
  localparam int unsigned OffsetBits  = 16;
  localparam int unsigned NumKw       = 14;

  localparam logic [5:0] K_COMMENT = 6'd16;
  localparam logic [5:0] K_UNKNOWN = 6'd23;
  localparam logic [5:0] K_EOF     = 6'd24;
  localparam logic [5:0] K_ID      = 6'd25;
  localparam logic [5:0] K_INT     = 6'd26;
  localparam logic [5:0] K_FLOAT   = 6'd27;
  localparam logic [5:0] K_STRING  = 6'd28;

  typedef enum logic [2:0] {
    M_IDLE, M_ID, M_INT, M_FRAC, M_STR, M_CMT, M_OP
  } mode_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start_res;
    logic [6:0]  length;
    logic [15:0] row;
    logic [15:0] col;
    logic        string_error;
    logic        overlong;
    logic        run_end;
  } res_t;

  // Up to three words caused by one byte.
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [2:0]       res;
  } batch_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_idstart(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_idchar(logic [7:0] c);
    return is_idstart(c) || is_digit(c);
  endfunction

  function automatic logic is_prefix(logic [7:0] c);
    return c == "<" || c == ">" || c == "=" || c == "!" || c == "+" || c == "-" || c == "/";
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "<": k = 6'd0;
      ">": k = 6'd2;
      "(": k = 6'd6;
      ")": k = 6'd7;
      "{": k = 6'd8;
      "}": k = 6'd9;
      "[": k = 6'd10;
      "]": k = 6'd11;
      "=": k = 6'd12;
      ":": k = 6'd13;
      ";": k = 6'd14;
      ",": k = 6'd15;
      "+": k = 6'd17;
      "-": k = 6'd18;
      "*": k = 6'd19;
      "/": k = 6'd20;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  // Bit 6 flags a two-character operator.
  function automatic logic [6:0] pair_kind(logic [7:0] h, logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (h == "<" && c == "=") r = {1'b1, 6'd1};
    if (h == ">" && c == "=") r = {1'b1, 6'd3};
    if (h == "=" && c == "=") r = {1'b1, 6'd4};
    if (h == "!" && c == "=") r = {1'b1, 6'd5};
    if (h == "+" && c == "+") r = {1'b1, 6'd21};
    if (h == "-" && c == "-") r = {1'b1, 6'd22};
    return r;
  endfunction

  // Keyword text, left-aligned in seven bytes.
  function automatic logic [55:0] kw_text(logic [3:0] k);
    logic [55:0] t;
    case (k)
      4'd0:  t = {"true", 24'h0};
      4'd1:  t = {"false", 16'h0};
      4'd2:  t = {"if", 40'h0};
      4'd3:  t = {"else", 24'h0};
      4'd4:  t = {"for", 32'h0};
      4'd5:  t = {"while", 16'h0};
      4'd6:  t = {"match", 16'h0};
      4'd7:  t = {"option", 8'h0};
      4'd8:  t = "default";
      4'd9:  t = {"break", 16'h0};
      4'd10: t = {"func", 24'h0};
      4'd11: t = {"return", 8'h0};
      4'd12: t = {"int", 32'h0};
      4'd13: t = {"float", 16'h0};
      default: t = 56'h0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(logic [3:0] k);
    logic [2:0] l;
    case (k)
      4'd2:                      l = 3'd2;
      4'd4, 4'd12:               l = 3'd3;
      4'd0, 4'd3, 4'd10:         l = 3'd4;
      4'd7, 4'd11:               l = 3'd6;
      4'd8:                      l = 3'd7;
      default:                   l = 3'd5;
    endcase
    return l;
  endfunction

  function automatic logic [5:0] kw_kind(logic [3:0] k);
    logic [5:0] r;
    case (k)
      4'd12, 4'd13: r = 6'd39;
      default:      r = 6'd29 + {2'b00, k};
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/stok_if.sv =====
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

interface stok_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  kind;
  logic [15:0] start_res;
  logic [6:0]  length;
  logic [15:0] row;
  logic [15:0] col;
  logic        string_error;
  logic        overlong;
  logic        run_end;
  modport source (output valid, kind, start_res, length, row, col, string_error, overlong,
                  run_end, input ready);
  modport sink (input valid, kind, start_res, length, row, col, string_error, overlong,
                run_end, output ready);
endinterface

// ===== hdl/source_tokenizer.sv =====
// Byte-serial tokenizer: takes one source byte per word on in_i and gives the
// tokens it completes on out_o, one token per word, each with kind, start
// offset, length, row and column; run_end marks the last token caused by a
// byte, and a byte marked last flushes the open token and adds an EOF token,
// after which the next byte starts a new source at offset 0. A byte is
// registered on entry, then combinational mode logic turns it into up to three
// tokens held in a small output buffer; a new byte is taken every cycle as
// long as each byte yields at most one token and the sink keeps up, while a
// byte that yields two or three tokens holds the input as the buffer drains,
// until it is down to its last token and the sink takes that token.
module source_tokenizer #(
  parameter int unsigned MAX_TOKEN_LEN = stok_pkg::MaxTokenLen,
  parameter int unsigned OFFSET_BITS   = stok_pkg::OffsetBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stok_in_if.sink     in_i,
  stok_out_if.source  out_o
);
  import stok_pkg::*;

  // Input register: hold one byte until the buffer can take its tokens.
  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       free;
  logic       proc;
  batch_t     batch;

  assign proc       = in_vld_q && free;
  assign in_i.ready = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q   <= in_i.ch;
      last_q <= in_i.last;
    end
  end

  // Mode logic: advance scan state and build this byte's tokens.
  stok_lexer #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (proc),
    .ch_i   (ch_q),
    .last_i (last_q),
    .batch_o(batch)
  );

  // Output buffer: drain the tokens one word at a time.
  stok_resbuf u_resbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (proc),
    .batch_i(batch),
    .free_o (free),
    .out_o  (out_o)
  );

`include "source_tokenizer_assert.svh"

  // A waiting byte is never dropped.
  `STOK_ASSERT_NEXT(a_hold_byte, clk_i, rst_ni, in_vld_q && !proc, in_vld_q)
  // The final byte always yields at least the EOF token.
  `STOK_ASSERT_NOW(a_eof_emitted, clk_i, rst_ni, proc && last_q, batch.cnt != 2'd0)
  // A byte without tokens leaves nothing on the output.
  `STOK_ASSERT_NEXT(a_empty_batch, clk_i, rst_ni, proc && batch.cnt == 2'd0, !out_o.valid)

endmodule

// ===== hdl/stok_lexer.sv =====
module stok_lexer #(
  parameter int unsigned MAX_TOKEN_LEN = stok_pkg::MaxTokenLen,
  parameter int unsigned OFFSET_BITS   = stok_pkg::OffsetBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      ch_i,
  input  logic            last_i,
  output stok_pkg::batch_t batch_o
);
  import stok_pkg::*;

  localparam int unsigned LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned OB = OFFSET_BITS;

  mode_e             mode_q, mode_d;
  logic [7:0]        held_q, held_d;
  logic [OB-1:0]     tstart_q, tstart_d, off_q, off_d, row_q, row_d, col_q, col_d;
  logic [OB-1:0]     srow_q, srow_d, scol_q, scol_d;
  logic [LW-1:0]     tlen_q, tlen_d;
  logic [NumKw-1:0]  kwc_q, kwc_d;
  logic              ovf_q, ovf_d;

  function automatic res_t mk_res(logic [5:0] kind, logic [OB-1:0] st, logic [LW-1:0] len,
                                  logic [OB-1:0] r, logic [OB-1:0] cl, logic se, logic ov);
    res_t o;
    logic [31:0] l32;
    l32            = 32'(len);
    o.kind         = kind;
    o.start_res    = 16'(st);
    o.length       = (l32 > 32'd127) ? 7'd127 : l32[6:0];
    o.row          = 16'(r);
    o.col          = 16'(cl);
    o.string_error = se;
    o.overlong     = ov;
    o.run_end      = 1'b0;
    return o;
  endfunction

  // Drop candidates whose next character differs or which are already complete.
  function automatic logic [NumKw-1:0] filt(logic [NumKw-1:0] kc, logic [LW-1:0] i,
                                            logic [7:0] c);
    logic [NumKw-1:0] r;
    logic [55:0]      t;
    logic [2:0]       i3;
    r  = kc;
    i3 = 3'(i);
    for (int k = 0; k < NumKw; k++) begin
      t = kw_text(4'(k));
      if (32'(i) >= 32'(kw_len(4'(k)))) r[k] = 1'b0;
      else if (t[55 - 8*i3 -: 8] != c) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [5:0] fin_kind(mode_e md, logic [NumKw-1:0] kc, logic [LW-1:0] tl,
                                          logic ov, logic [7:0] h);
    logic [5:0] k;
    case (md)
      M_ID: begin
        k = K_ID;
        if (!ov)
          for (int j = 0; j < NumKw; j++)
            if (kc[j] && 32'(kw_len(4'(j))) == 32'(tl)) k = kw_kind(4'(j));
      end
      M_INT:  k = K_INT;
      M_FRAC: k = K_FLOAT;
      M_STR:  k = K_STRING;
      M_CMT:  k = K_COMMENT;
      default: k = single_kind(h);
    endcase
    return k;
  endfunction

  always_comb begin
    logic       used;
    logic [1:0] n;
    logic [6:0] pk;
    res_t [2:0] res;
    mode_d = mode_q; held_d = held_q; tstart_d = tstart_q; tlen_d = tlen_q;
    off_d = off_q; row_d = row_q; col_d = col_q; srow_d = srow_q; scol_d = scol_q;
    kwc_d = kwc_q; ovf_d = ovf_q;
    used = 1'b0;
    n = 2'd0;
    res = '0;
    pk = pair_kind(held_q, ch_i);

    case (mode_q)
      M_ID: begin
        if (is_idchar(ch_i)) begin
          kwc_d = filt(kwc_d, tlen_d, ch_i);
          if (32'(tlen_d) < MAX_TOKEN_LEN) tlen_d = tlen_d + LW'(1);
          else ovf_d = 1'b1;
          used = 1'b1;
        end
      end
      M_INT: begin
        if (is_digit(ch_i) || ch_i == ".") begin
          if (32'(tlen_d) < MAX_TOKEN_LEN) tlen_d = tlen_d + LW'(1);
          else ovf_d = 1'b1;
          if (ch_i == ".") mode_d = M_FRAC;
          used = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_digit(ch_i)) begin
          if (32'(tlen_d) < MAX_TOKEN_LEN) tlen_d = tlen_d + LW'(1);
          else ovf_d = 1'b1;
          used = 1'b1;
        end
      end
      M_STR, M_CMT: begin
        if (ch_i != 8'h0A) begin
          if (32'(tlen_d) < MAX_TOKEN_LEN) tlen_d = tlen_d + LW'(1);
          else ovf_d = 1'b1;
          used = 1'b1;
        end
      end
      M_OP: begin
        if (pk[6]) begin
          res[n] = mk_res(pk[5:0], tstart_d, LW'(2), srow_d, scol_d, 1'b0, 1'b0);
          n = n + 2'd1;
          mode_d = M_IDLE;
          used = 1'b1;
        end else if (held_q == "/" && ch_i == "/") begin
          mode_d = M_CMT;
          tlen_d = LW'(2);
          used = 1'b1;
        end
      end
      default: mode_d = M_IDLE;
    endcase

    // Close the open token when the byte does not extend it; a closing
    // quote is taken into the string first.
    if (mode_q != M_IDLE && mode_q != M_OP && !used) begin
      res[n] = mk_res(fin_kind(mode_q, kwc_d, tlen_d, ovf_d, held_d), tstart_d, tlen_d,
                      srow_d, scol_d, mode_q == M_STR, ovf_d);
      n = n + 2'd1;
      mode_d = M_IDLE;
    end else if (mode_q == M_STR && ch_i == "\"") begin
      res[n] = mk_res(K_STRING, tstart_d, tlen_d, srow_d, scol_d, 1'b0, ovf_d);
      n = n + 2'd1;
      mode_d = M_IDLE;
    end else if (mode_q == M_OP && !used) begin
      res[n] = mk_res(single_kind(held_d), tstart_d, tlen_d, srow_d, scol_d, 1'b0, ovf_d);
      n = n + 2'd1;
      mode_d = M_IDLE;
    end

    if (!used && mode_d == M_IDLE && !is_space(ch_i)) begin
      if (is_digit(ch_i) || is_idstart(ch_i) || ch_i == "\"" || is_prefix(ch_i)) begin
        tstart_d = off_q; srow_d = row_q; scol_d = col_q;
        tlen_d = LW'(1); ovf_d = 1'b0;
        if (is_digit(ch_i)) mode_d = M_INT;
        else if (is_idstart(ch_i)) begin
          mode_d = M_ID;
          kwc_d = filt('1, '0, ch_i);
        end else if (ch_i == "\"") mode_d = M_STR;
        else begin
          mode_d = M_OP;
          held_d = ch_i;
        end
      end else begin
        res[n] = mk_res(single_kind(ch_i), off_q, LW'(1), row_q, col_q, 1'b0, 1'b0);
        n = n + 2'd1;
      end
    end

    off_d = off_q + OB'(1);
    if (ch_i == 8'h0A) begin
      row_d = row_q + OB'(1);
      col_d = '0;
    end else begin
      col_d = col_q + OB'(1);
    end

    if (last_i) begin
      if (mode_d != M_IDLE) begin
        res[n] = mk_res(fin_kind(mode_d, kwc_d, tlen_d, ovf_d, held_d), tstart_d, tlen_d,
                        srow_d, scol_d, mode_d == M_STR, ovf_d);
        n = n + 2'd1;
      end
      res[n] = mk_res(K_EOF, off_d, '0, row_d, col_d, 1'b0, 1'b0);
      n = n + 2'd1;
      mode_d = M_IDLE; held_d = '0; tstart_d = '0; tlen_d = '0;
      off_d = '0; row_d = '0; col_d = '0; srow_d = '0; scol_d = '0;
      kwc_d = '1; ovf_d = 1'b0;
    end

    if (n != 2'd0) res[n - 2'd1].run_end = 1'b1;
    batch_o.cnt = n;
    batch_o.res = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; held_q <= '0; tstart_q <= '0; tlen_q <= '0;
      off_q <= '0; row_q <= '0; col_q <= '0; srow_q <= '0; scol_q <= '0;
      kwc_q <= '1; ovf_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d; held_q <= held_d; tstart_q <= tstart_d; tlen_q <= tlen_d;
      off_q <= off_d; row_q <= row_d; col_q <= col_d; srow_q <= srow_d; scol_q <= scol_d;
      kwc_q <= kwc_d; ovf_q <= ovf_d;
    end
  end

endmodule

// ===== hdl/stok_resbuf.sv =====
module stok_resbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  stok_pkg::batch_t batch_i,
  output logic             free_o,
  stok_out_if.source       out_o
);
  import stok_pkg::*;

  res_t [2:0] buf_q;
  logic [1:0] cnt_q, idx_q;
  res_t       cur;
  logic       take;

  assign take   = out_o.valid && out_o.ready;
  assign free_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_o.ready);
  assign cur    = buf_q[idx_q];

  assign out_o.valid        = cnt_q != 2'd0;
  assign out_o.kind         = cur.kind;
  assign out_o.start_res    = cur.start_res;
  assign out_o.length       = cur.length;
  assign out_o.row          = cur.row;
  assign out_o.col          = cur.col;
  assign out_o.string_error = cur.string_error;
  assign out_o.overlong     = cur.overlong;
  assign out_o.run_end      = cur.run_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.cnt;
      idx_q <= '0;
    end else if (take) begin
      cnt_q <= cnt_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) buf_q <= batch_i.res;
  end

endmodule
